/* src/sta_pkg.sv */
// Shared types and constants for the session table with age-out.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sta_pkg;

   localparam int SLOT_W   = 6;
   localparam int STAMP_W  = 32;
   localparam int STATUS_W = 3;
   localparam int TMO_W    = 8;
   localparam int KLEN_W   = 5;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [STATUS_W-1:0] STATUS_HIT   = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NEW   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_EVICT = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_TICK  = 3'd4;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // register index, taken from paddr[2]
   localparam logic REG_TIMEOUT = 1'b0;
   localparam logic REG_EVICT   = 1'b1;

   localparam logic [TMO_W-1:0] TIMEOUT_RESET = 8'd5;
   localparam logic             EVICT_RESET   = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic [63:0]       client_ip_high;
      logic [63:0]       client_ip_low;
      logic [15:0]       client_port;
      logic [31:0]       client_flow_label;
      logic [31:0]       client_scope;
      logic [KLEN_W-1:0] key_length;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
   } rsp_type;

   typedef struct packed {
      logic [63:0]       ip_high;
      logic [63:0]       ip_low;
      logic [15:0]       port;
      logic [31:0]       flow_label;
      logic [31:0]       scope;
      logic [KLEN_W-1:0] key_length;
   } key_type;

   // update command from the top level to the slot bank
   typedef struct packed {
      logic              query;
      logic              alloc;
      logic [SLOT_W-1:0] idx;
   } slot_cmd_type;

   // lookup outcome from the slot picker
   typedef struct packed {
      logic              hit;
      logic              free;
      logic [SLOT_W-1:0] hit_idx;
      logic [SLOT_W-1:0] free_idx;
      logic [SLOT_W-1:0] old_idx;
   } pick_type;

endpackage

`default_nettype wire

/* src/sta_slot_bank.sv */
// Slot storage: valid bits, keys and stamps, with per-slot live and match flags.
// Depends on sta_pkg.
`default_nettype none

module sta_slot_bank #(
   parameter int SESSIONS = 3
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire sta_pkg::key_type                            key,
   input  wire logic [sta_pkg::STAMP_W-1:0]                 now,
   input  wire logic [sta_pkg::TMO_W-1:0]                   timeout,
   input  wire sta_pkg::slot_cmd_type                       cmd,
   output logic [SESSIONS-1:0]                              live,
   output logic [SESSIONS-1:0]                              match,
   output logic [SESSIONS-1:0][sta_pkg::STAMP_W-1:0]        stamps
);
   import sta_pkg::*;

   logic    [SESSIONS-1:0]              valid_ff, valid_in;
   key_type [SESSIONS-1:0]              key_ff;
   logic    [SESSIONS-1:0][STAMP_W-1:0] stamp_ff;
   logic    [SESSIONS-1:0]              wr_sel;

   always_comb begin
      for (int k = 0; k < SESSIONS; k++) begin
         live[k]   = valid_ff[k] &&
                     ((now - stamp_ff[k]) <= {{(STAMP_W-TMO_W){1'b0}}, timeout});
         match[k]  = live[k] && (key_ff[k] == key);
         stamps[k] = stamp_ff[k];
         wr_sel[k] = cmd.alloc && (cmd.idx == SLOT_W'(k));
         // a query drops expired slots before it allocates
         valid_in[k] = cmd.query ? (live[k] || wr_sel[k]) : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SESSIONS; k++) begin
         if (wr_sel[k]) begin
            key_ff[k]   <= key;
            stamp_ff[k] <= now;
         end
      end
   end

endmodule

`default_nettype wire

/* src/sta_pick.sv */
// Slot picker: first hit, first free slot and oldest stamp over the slot flags.
// Depends on sta_pkg.
`default_nettype none

module sta_pick #(
   parameter int SESSIONS = 3
) (
   input  wire logic [SESSIONS-1:0]                         live,
   input  wire logic [SESSIONS-1:0]                         match,
   input  wire logic [SESSIONS-1:0][sta_pkg::STAMP_W-1:0]   stamps,
   output sta_pkg::pick_type                                pick
);
   import sta_pkg::*;

   logic [STAMP_W-1:0] least;

   always_comb begin
      pick = '0;
      // walk downward so the lowest index wins
      for (int k = SESSIONS - 1; k >= 0; k--) begin
         if (match[k]) begin
            pick.hit     = 1'b1;
            pick.hit_idx = SLOT_W'(k);
         end
         if (!live[k]) begin
            pick.free     = 1'b1;
            pick.free_idx = SLOT_W'(k);
         end
      end
      // strict compare keeps the lowest index on a tie
      least = '1;
      for (int k = 0; k < SESSIONS; k++) begin
         if (stamps[k] < least) begin
            least        = stamps[k];
            pick.old_idx = SLOT_W'(k);
         end
      end
   end

endmodule

`default_nettype wire

/* src/session_table_with_ageout.sv */
// Top level of the session table: request register, slot bank, picker,
// seconds counter, control registers and response register. Depends on sta_pkg.
`default_nettype none

// Channel    Ports                          Direction  Content
// request    req_valid req_stall req_data   in         req_type: tick or key query
// response   rsp_valid rsp_stall rsp_data   out        rsp_type: status and slot
// control    psel penable pwrite paddr ...  in/out     timeout_seconds @0, evict_enable @4
//
// One request per cycle, sustained while the response is not stalled: a request
// is held in the request register, is resolved against the slot bank and lands
// in the response register, which drives rsp_valid. The parallel key compare and
// the oldest-stamp select over all slots set the cycle time.
// Reset clears the slot valid bits, the seconds counter and the valid bits of both
// pipeline registers, and restores timeout 5 and eviction on; keys and stamps are not reset.
// A stalled response holds the request register, and req_stall rises while that holds a request.

module session_table_with_ageout #(
   parameter int SESSIONS = 3
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire sta_pkg::req_type               req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output sta_pkg::rsp_type                    rsp_data,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [sta_pkg::CSR_AW-1:0]     paddr,
   input  wire logic [sta_pkg::CSR_DW-1:0]     pwdata,
   output logic [sta_pkg::CSR_DW-1:0]          prdata,
   output logic                                pready
);
   import sta_pkg::*;

   // request register
   logic    in_valid_ff, in_valid_in;
   req_type in_ff;
   // response register
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   // seconds counter and control registers
   logic [STAMP_W-1:0] now_ff, now_in;
   logic [TMO_W-1:0]   timeout_ff, timeout_in;
   logic               evict_ff, evict_in;

   logic                             advance, fire, accept, csr_wr;
   key_type                          key;
   slot_cmd_type                     cmd;
   pick_type                         pick;
   logic [SESSIONS-1:0]              live, match;
   logic [SESSIONS-1:0][STAMP_W-1:0] stamps;

   // The response register frees up when empty or being taken this cycle.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign key = '{ip_high:    in_ff.client_ip_high,
                  ip_low:     in_ff.client_ip_low,
                  port:       in_ff.client_port,
                  flow_label: in_ff.client_flow_label,
                  scope:      in_ff.client_scope,
                  key_length: in_ff.key_length};

   sta_slot_bank #(.SESSIONS(SESSIONS)) u_bank (
      .clock   (clock),
      .reset   (reset),
      .key     (key),
      .now     (now_ff),
      .timeout (timeout_ff),
      .cmd     (cmd),
      .live    (live),
      .match   (match),
      .stamps  (stamps)
   );

   sta_pick #(.SESSIONS(SESSIONS)) u_pick (
      .live   (live),
      .match  (match),
      .stamps (stamps),
      .pick   (pick)
   );

   // Resolve the held request: tick; or hit, then first free, then evict or full.
   always_comb begin
      cmd       = '0;
      cmd.query = fire && (in_ff.opcode == OP_QUERY);
      out_in    = '{status: STATUS_TICK, slot: '0};
      now_in    = now_ff;
      if (fire && (in_ff.opcode == OP_TICK)) begin
         now_in = now_ff + STAMP_W'(1);
      end
      if (in_ff.opcode == OP_QUERY) begin
         if (pick.hit) begin
            out_in = '{status: STATUS_HIT, slot: pick.hit_idx};
         end else if (pick.free) begin
            out_in    = '{status: STATUS_NEW, slot: pick.free_idx};
            cmd.alloc = fire;
            cmd.idx   = pick.free_idx;
         end else if (evict_ff) begin
            out_in    = '{status: STATUS_EVICT, slot: pick.old_idx};
            cmd.alloc = fire;
            cmd.idx   = pick.old_idx;
         end else begin
            out_in = '{status: STATUS_FULL, slot: '0};
         end
      end
   end

   // Pipeline valid bits: load on accept or fire, drop once consumed.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // Control register writes; the register index is paddr[2].
   assign csr_wr = psel && penable && pwrite && pready;
   always_comb begin
      timeout_in = timeout_ff;
      evict_in   = evict_ff;
      if (csr_wr) begin
         unique case (paddr[2])
            REG_TIMEOUT: timeout_in = pwdata[TMO_W-1:0];
            REG_EVICT:   evict_in   = pwdata[0];
            default:     ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_TIMEOUT: prdata = {{(CSR_DW-TMO_W){1'b0}}, timeout_ff};
         REG_EVICT:   prdata = {{(CSR_DW-1){1'b0}}, evict_ff};
         default:     prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         now_ff       <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         evict_ff     <= EVICT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         now_ff       <= now_in;
         timeout_ff   <= timeout_in;
         evict_ff     <= evict_in;
      end
   end

   // Payload registers: hold while stalled.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_data;
      end
      if (fire) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

/* src/sta_checker.sv */
// Port-level checks for the session table, bound to the top level.
// Depends on sta_pkg and session_table_with_ageout.
`default_nettype none

module sta_checker #(
   parameter int SESSIONS = 3
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire sta_pkg::rsp_type rsp_data,
   input wire logic             pready
);
   import sta_pkg::*;

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // tick and full carry slot zero; other results name a slot that exists
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_TICK || rsp_data.status == STATUS_FULL)
      |-> rsp_data.slot == '0)
      else $error("tick or full with nonzero slot");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status <= STATUS_TICK) &&
                    ({1'b0, rsp_data.slot} < (SLOT_W+1)'(SESSIONS)))
      else $error("bad status or slot out of range");

   assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind session_table_with_ageout sta_checker #(.SESSIONS(SESSIONS)) u_sta_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .pready    (pready)
);

`default_nettype wire
